>>> design/hbw_pkg.sv
// types and constants shared by the heartbeat watchdog modules
// no dependencies
package hbw_pkg;

   localparam int NUM_CPUS  = 4;
   localparam int CPU_IDX_W = 2;
   localparam int MASK_W    = 4;
   localparam int COUNT_W   = 16;
   localparam int PERIOD_W  = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // request kinds
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_CHECKIN = 1'b1;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_CPU_MASK      = 2'd0;
   localparam logic [1:0] REG_SOFT_TIMEOUT  = 2'd1;
   localparam logic [1:0] REG_COMPLAIN      = 2'd2;
   localparam logic [1:0] REG_CRASH_DISABLE = 2'd3;

   localparam logic [MASK_W-1:0]   RST_CPU_MASK      = 4'd1;
   localparam logic [COUNT_W-1:0]  RST_SOFT_TIMEOUT  = 16'd120;
   localparam logic [PERIOD_W-1:0] RST_COMPLAIN      = 8'd10;
   localparam logic                RST_CRASH_DISABLE = 1'b0;

   typedef struct packed {
      logic [MASK_W-1:0]   cpu_mask;
      logic [COUNT_W-1:0]  soft_timeout_seconds;
      logic [PERIOD_W-1:0] complain_period;
      logic                crash_disable;
   } cfg_type;

   typedef struct packed {
      logic                 opcode;
      logic [CPU_IDX_W-1:0] cpu_index;
      logic                 crash_pending;
   } req_item_type;

   // first field in the highest bits
   typedef struct packed {
      logic [MASK_W-1:0]  checkin_mask;
      logic [COUNT_W-1:0] countdown_now;
      logic               halted;
      logic               crash_request;
      logic               report_timeout;
      logic               report_unblocked;
      logic               report_blocked;
      logic               hw_kick;
   } rsp_item_type;

   function automatic logic cpu_present(input logic [CPU_IDX_W-1:0] idx);
      return int'(idx) < NUM_CPUS;
   endfunction

endpackage

>>> design/multi_cpu_heartbeat_watchdog_unit.sv
// top level of the multi-cpu heartbeat watchdog: request and response stages
// depends on hbw_pkg, hbw_csr and hbw_core
module multi_cpu_heartbeat_watchdog_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // cpu_index[1:0], crash_pending[2]
   input  logic                           req_tuser,  // opcode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // hw_kick[0], report_blocked[1], report_unblocked[2], report_timeout[3],
   // crash_request[4], halted[5], countdown_now[21:6], checkin_mask[25:22]
   output logic [31:0]                    rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [hbw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hbw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hbw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   // Heartbeat watchdog for up to four CPUs. Each request is a CPU check-in
   // (tuser high) or a one-second tick (tuser low) and produces exactly one
   // response, in order. A request enters a register stage, is evaluated
   // against the watchdog state combinationally and its response is held in an
   // output register; one request is taken every clock cycle while the response
   // side is not stalled. A request passes from the input register to the
   // output register, which holds its response until it is taken.
   // Registers: cpu_mask at 0x0, soft_timeout_seconds at 0x4,
   // complain_period at 0x8, crash_disable at 0xC; write them only while no
   // request is in flight.
   import hbw_pkg::*;

   cfg_type      cfg;
   req_item_type item_in, item_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type result, out_item_ff;
   logic         out_valid_ff, out_valid_in;
   logic         advance;

   hbw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hbw_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item_ff),
      .update (advance),
      .result (result)
   );

   assign item_in.opcode        = req_tuser;
   assign item_in.cpu_index     = req_tdata[CPU_IDX_W-1:0];
   assign item_in.crash_pending = req_tdata[CPU_IDX_W];

   // request moves on when the response register is free or being drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(32 - $bits(rsp_item_type))'(0), out_item_ff};

endmodule

>>> design/hbw_csr.sv
// configuration registers of the heartbeat watchdog, apb-style access
// depends on hbw_pkg
module hbw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hbw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hbw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hbw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output hbw_pkg::cfg_type              cfg
);
   import hbw_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_CPU_MASK:      cfg_in.cpu_mask = csr_pwdata[MASK_W-1:0];
            REG_SOFT_TIMEOUT:  cfg_in.soft_timeout_seconds = csr_pwdata[COUNT_W-1:0];
            REG_COMPLAIN:      cfg_in.complain_period = csr_pwdata[PERIOD_W-1:0];
            REG_CRASH_DISABLE: cfg_in.crash_disable = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cpu_mask             <= RST_CPU_MASK;
         cfg_ff.soft_timeout_seconds <= RST_SOFT_TIMEOUT;
         cfg_ff.complain_period      <= RST_COMPLAIN;
         cfg_ff.crash_disable        <= RST_CRASH_DISABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_CPU_MASK:      csr_prdata = CSR_DATA_W'(cfg_ff.cpu_mask);
         REG_SOFT_TIMEOUT:  csr_prdata = CSR_DATA_W'(cfg_ff.soft_timeout_seconds);
         REG_COMPLAIN:      csr_prdata = CSR_DATA_W'(cfg_ff.complain_period);
         REG_CRASH_DISABLE: csr_prdata = CSR_DATA_W'(cfg_ff.crash_disable);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> design/hbw_core.sv
// watchdog state and the per-request update logic
// depends on hbw_pkg
module hbw_core (
   input  logic                  clock,
   input  logic                  reset,
   input  hbw_pkg::cfg_type      cfg,
   input  hbw_pkg::req_item_type item,
   input  logic                  update,
   output hbw_pkg::rsp_item_type result
);
   import hbw_pkg::*;

   logic [COUNT_W-1:0]  countdown_ff, countdown_in;
   logic [PERIOD_W-1:0] phase_ff, phase_in;
   logic [MASK_W-1:0]   pending_ff, pending_in;
   logic                stall_ff, stall_in;
   logic                stopped_ff, stopped_in;

   logic                full;
   logic [COUNT_W-1:0]  cd_rel;
   logic [PERIOD_W-1:0] ph_rel, ph_next;
   logic                blk;

   // reload first, then stall check against the reloaded values
   assign full   = (pending_ff == cfg.cpu_mask);
   assign cd_rel = full ? cfg.soft_timeout_seconds : countdown_ff;
   assign ph_rel = full ? '0 : phase_ff;
   assign blk    = (cd_rel < cfg.soft_timeout_seconds) && (ph_rel == '0);

   // period of zero behaves as one
   always_comb begin
      ph_next = ph_rel + PERIOD_W'(1);
      if (ph_next >= cfg.complain_period) begin
         ph_next = '0;
      end
   end

   always_comb begin
      countdown_in = countdown_ff;
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      stall_in     = stall_ff;
      stopped_in   = stopped_ff;
      result       = '0;
      if (item.opcode == OP_CHECKIN) begin
         if (cpu_present(item.cpu_index)) begin
            pending_in = pending_ff | (MASK_W'(1) << item.cpu_index);
         end
      end else if (!stopped_ff) begin
         if (item.crash_pending) begin
            stopped_in = 1'b1;
         end else begin
            result.hw_kick          = 1'b1;
            result.report_unblocked = full && stall_ff;
            result.report_blocked   = blk;
            stall_in   = blk || (stall_ff && !full);
            pending_in = (full || blk) ? '0 : pending_ff;
            if (cd_rel == '0) begin
               result.report_timeout = 1'b1;
               countdown_in = '0;
               if (!cfg.crash_disable) begin
                  result.crash_request = 1'b1;
                  stopped_in = 1'b1;
                  phase_in   = ph_rel;
               end else begin
                  phase_in = ph_next;
               end
            end else begin
               countdown_in = cd_rel - COUNT_W'(1);
               phase_in     = ph_next;
            end
         end
      end
      result.halted        = stopped_in;
      result.countdown_now = countdown_in;
      result.checkin_mask  = pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= RST_SOFT_TIMEOUT;
         phase_ff     <= '0;
         pending_ff   <= '0;
         stall_ff     <= 1'b0;
         stopped_ff   <= 1'b0;
      end else if (update) begin
         countdown_ff <= countdown_in;
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         stall_ff     <= stall_in;
         stopped_ff   <= stopped_in;
      end
   end

`ifndef SYNTHESIS
   // only reset releases a halt
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halt released without reset");

   a_no_kick_halted: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !result.hw_kick && !result.crash_request)
      else $error("watchdog kicked while halted");

   a_blk_unblk_excl: assert property (@(posedge clock) disable iff (reset)
      !(result.report_blocked && result.report_unblocked))
      else $error("stall reported and cleared on one tick");

   a_checkin_sets: assert property (@(posedge clock) disable iff (reset)
      update && item.opcode == OP_CHECKIN && cpu_present(item.cpu_index)
      |=> pending_ff != '0)
      else $error("check-in left pending mask empty");
`endif

endmodule
